// File: hw/rtl/rmc_pkg.sv
// Shared types and constants for the ray march circle occluder.
// No dependencies; the config interface and every module of the block import this package.
`timescale 1ns / 1ps

package rmc_pkg;

  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_OBSTACLE_X      = 3'd0,
    CFG_OBSTACLE_Y      = 3'd1,
    CFG_OBSTACLE_RADIUS = 3'd2,
    CFG_SCREEN_WIDTH    = 3'd3,
    CFG_SCREEN_HEIGHT   = 3'd4
  } cfg_idx_t;

  localparam int RST_OBSTACLE_X      = 650;
  localparam int RST_OBSTACLE_Y      = 300;
  localparam int RST_OBSTACLE_RADIUS = 140;
  localparam int RST_SCREEN_WIDTH    = 1200;
  localparam int RST_SCREEN_HEIGHT   = 600;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  typedef struct packed {
    logic valid;
    logic is_step;
  } rmc_ctl_t;

endpackage

// File: hw/rtl/rmc_in_if.sv
// Input channel of the ray march block: valid/ready and one load or step item.
// Widths follow COORD_BITS and FRAC_BITS; no other dependencies.
`timescale 1ns / 1ps

interface rmc_in_if #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
);
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [COORD_BITS-1:0]       start_x;
  logic [COORD_BITS-1:0]       start_y;
  logic signed [FRAC_BITS+1:0] dir_x;
  logic signed [FRAC_BITS+1:0] dir_y;

  modport source (output valid, mode, start_x, start_y, dir_x, dir_y, input ready);
  modport sink   (input valid, mode, start_x, start_y, dir_x, dir_y, output ready);
endinterface

// File: hw/rtl/rmc_out_if.sv
// Result channel of the ray march block: valid/ready and one pixel result.
// Widths follow COORD_BITS; no other dependencies.
`timescale 1ns / 1ps

interface rmc_out_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic                         pixel_valid;
  logic signed [COORD_BITS+1:0] pixel_x;
  logic signed [COORD_BITS+1:0] pixel_y;
  logic                         hit;
  logic                         off_screen;
  logic                         ray_done;

  modport source (output valid, pixel_valid, pixel_x, pixel_y, hit, off_screen, ray_done,
                  input ready);
  modport sink   (input valid, pixel_valid, pixel_x, pixel_y, hit, off_screen, ray_done,
                  output ready);
endinterface

// File: hw/rtl/rmc_cfg_if.sv
// Configuration write channel of the ray march block: valid/ready, index and data.
// Uses CFG_IDX_BITS from rmc_pkg.
`timescale 1ns / 1ps

interface rmc_cfg_if
  import rmc_pkg::*;
#(
  parameter int COORD_BITS = 12
);
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [COORD_BITS:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/rmc_cfg_regs.sv
// Configuration registers for obstacle and screen bounds, plus the registered
// square of the obstacle radius. Depends on rmc_pkg.
`timescale 1ns / 1ps

module rmc_cfg_regs
  import rmc_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS:0]     cfg_data,
  output logic [COORD_BITS-1:0]   obstacle_x,
  output logic [COORD_BITS-1:0]   obstacle_y,
  output logic [COORD_BITS:0]     screen_width,
  output logic [COORD_BITS:0]     screen_height,
  output logic [2*COORD_BITS-1:0] obstacle_r2
);

  logic [COORD_BITS-1:0]   obstacle_x_r;
  logic [COORD_BITS-1:0]   obstacle_y_r;
  logic [COORD_BITS-1:0]   radius_r;
  logic [COORD_BITS:0]     screen_width_r;
  logic [COORD_BITS:0]     screen_height_r;
  logic [2*COORD_BITS-1:0] obstacle_r2_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obstacle_x_r    <= COORD_BITS'(RST_OBSTACLE_X);
      obstacle_y_r    <= COORD_BITS'(RST_OBSTACLE_Y);
      radius_r        <= COORD_BITS'(RST_OBSTACLE_RADIUS);
      screen_width_r  <= (COORD_BITS+1)'(RST_SCREEN_WIDTH);
      screen_height_r <= (COORD_BITS+1)'(RST_SCREEN_HEIGHT);
      obstacle_r2_r   <= (2*COORD_BITS)'(RST_OBSTACLE_RADIUS * RST_OBSTACLE_RADIUS);
    end else begin
      obstacle_r2_r <= (2*COORD_BITS)'(radius_r) * (2*COORD_BITS)'(radius_r);
      if (cfg_valid) begin
        case (cfg_idx_t'(cfg_index))
          CFG_OBSTACLE_X:      obstacle_x_r    <= cfg_data[COORD_BITS-1:0];
          CFG_OBSTACLE_Y:      obstacle_y_r    <= cfg_data[COORD_BITS-1:0];
          CFG_OBSTACLE_RADIUS: radius_r        <= cfg_data[COORD_BITS-1:0];
          CFG_SCREEN_WIDTH:    screen_width_r  <= cfg_data;
          CFG_SCREEN_HEIGHT:   screen_height_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign obstacle_x    = obstacle_x_r;
  assign obstacle_y    = obstacle_y_r;
  assign screen_width  = screen_width_r;
  assign screen_height = screen_height_r;
  assign obstacle_r2   = obstacle_r2_r;

endmodule

// File: hw/rtl/rmc_advance.sv
// Input stage: accepts load and step items and advances the ray position.
// The position register doubles as the stage payload. Depends on rmc_pkg.
`timescale 1ns / 1ps

module rmc_advance
  import rmc_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    in_mode,
  input  logic [COORD_BITS-1:0]                   in_start_x,
  input  logic [COORD_BITS-1:0]                   in_start_y,
  input  logic signed [FRAC_BITS+1:0]             in_dir_x,
  input  logic signed [FRAC_BITS+1:0]             in_dir_y,
  input  logic                                    s1_ready,
  output rmc_ctl_t                                s1_ctl,
  output logic signed [COORD_BITS+FRAC_BITS+1:0]  pos_x,
  output logic signed [COORD_BITS+FRAC_BITS+1:0]  pos_y
);

  localparam int POS_BITS = COORD_BITS + FRAC_BITS + 2;
  localparam int DIR_BITS = FRAC_BITS + 2;

  rmc_ctl_t                   s1_ctl_r;
  logic signed [POS_BITS-1:0] pos_x_r, pos_x_nxt;
  logic signed [POS_BITS-1:0] pos_y_r, pos_y_nxt;
  logic signed [DIR_BITS-1:0] step_x_r, step_y_r;
  logic                       in_fire;

  assign in_ready = !s1_ctl_r.valid || s1_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    if (in_mode == MODE_STEP) begin
      pos_x_nxt = pos_x_r + {{(POS_BITS-DIR_BITS){step_x_r[DIR_BITS-1]}}, step_x_r};
      pos_y_nxt = pos_y_r + {{(POS_BITS-DIR_BITS){step_y_r[DIR_BITS-1]}}, step_y_r};
    end else begin
      pos_x_nxt = {2'b00, in_start_x, {FRAC_BITS{1'b0}}};
      pos_y_nxt = {2'b00, in_start_y, {FRAC_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      step_x_r <= '0;
      step_y_r <= '0;
    end else begin
      if (in_ready) begin
        s1_ctl_r.valid   <= in_valid;
        s1_ctl_r.is_step <= in_mode;
      end
      if (in_fire) begin
        pos_x_r <= pos_x_nxt;
        pos_y_r <= pos_y_nxt;
        if (in_mode == MODE_LOAD) begin
          step_x_r <= in_dir_x;
          step_y_r <= in_dir_y;
        end
      end
    end
  end

  assign s1_ctl = s1_ctl_r;
  assign pos_x  = pos_x_r;
  assign pos_y  = pos_y_r;

endmodule

// File: hw/rtl/rmc_geom.sv
// Geometry stage: screen bound test, pixel truncation and the squared offsets
// from the obstacle center. Depends on rmc_pkg.
`timescale 1ns / 1ps

module rmc_geom
  import rmc_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  rmc_ctl_t                                   s1_ctl,
  output logic                                       s1_ready,
  input  logic signed [COORD_BITS+FRAC_BITS+1:0]     pos_x,
  input  logic signed [COORD_BITS+FRAC_BITS+1:0]     pos_y,
  input  logic [COORD_BITS-1:0]                      obstacle_x,
  input  logic [COORD_BITS-1:0]                      obstacle_y,
  input  logic [COORD_BITS:0]                        screen_width,
  input  logic [COORD_BITS:0]                        screen_height,
  input  logic                                       s2_ready,
  output rmc_ctl_t                                   s2_ctl,
  output logic [2*(COORD_BITS+FRAC_BITS+2)-1:0]      sq_x,
  output logic [2*(COORD_BITS+FRAC_BITS+2)-1:0]      sq_y,
  output logic                                       off_screen,
  output logic signed [COORD_BITS+1:0]               pixel_x,
  output logic signed [COORD_BITS+1:0]               pixel_y
);

  localparam int POS_BITS = COORD_BITS + FRAC_BITS + 2;
  localparam int PIX_BITS = COORD_BITS + 2;

  function automatic logic [PIX_BITS-1:0] trunc_pixel(input logic [POS_BITS-1:0] p);
    logic [POS_BITS-1:0] neg_p;
    logic [POS_BITS-1:0] mag_p;
    logic [PIX_BITS-1:0] q;
    neg_p = -p;
    mag_p = p[POS_BITS-1] ? neg_p : p;
    q     = mag_p[POS_BITS-1:FRAC_BITS];
    return p[POS_BITS-1] ? -q : q;
  endfunction

  rmc_ctl_t                   s2_ctl_r;
  logic [2*POS_BITS-1:0]      sq_x_r, sq_y_r, sq_x_nxt, sq_y_nxt;
  logic                       off_r, off_nxt;
  logic [PIX_BITS-1:0]        pixel_x_r, pixel_y_r;
  logic signed [POS_BITS:0]   dx, dy, neg_dx, neg_dy;
  logic [POS_BITS-1:0]        mag_x, mag_y;

  assign s1_ready = !s2_ctl_r.valid || s2_ready;

  assign dx     = {pos_x[POS_BITS-1], pos_x} - {3'b000, obstacle_x, {FRAC_BITS{1'b0}}};
  assign dy     = {pos_y[POS_BITS-1], pos_y} - {3'b000, obstacle_y, {FRAC_BITS{1'b0}}};
  assign neg_dx = -dx;
  assign neg_dy = -dy;
  assign mag_x  = dx[POS_BITS] ? neg_dx[POS_BITS-1:0] : dx[POS_BITS-1:0];
  assign mag_y  = dy[POS_BITS] ? neg_dy[POS_BITS-1:0] : dy[POS_BITS-1:0];

  assign sq_x_nxt = mag_x * mag_x;
  assign sq_y_nxt = mag_y * mag_y;

  assign off_nxt = pos_x[POS_BITS-1] || pos_y[POS_BITS-1] ||
                   (pos_x[POS_BITS-2:FRAC_BITS] >= screen_width) ||
                   (pos_y[POS_BITS-2:FRAC_BITS] >= screen_height);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else if (s1_ready) begin
      s2_ctl_r <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_ctl.valid) begin
      sq_x_r    <= sq_x_nxt;
      sq_y_r    <= sq_y_nxt;
      off_r     <= off_nxt;
      pixel_x_r <= trunc_pixel(pos_x);
      pixel_y_r <= trunc_pixel(pos_y);
    end
  end

  assign s2_ctl     = s2_ctl_r;
  assign sq_x       = sq_x_r;
  assign sq_y       = sq_y_r;
  assign off_screen = off_r;
  assign pixel_x    = pixel_x_r;
  assign pixel_y    = pixel_y_r;

endmodule

// File: hw/rtl/rmc_resolve.sv
// Output stage: circle hit test, ray end tracking and the result register.
// Depends on rmc_pkg.
`timescale 1ns / 1ps

module rmc_resolve
  import rmc_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  rmc_ctl_t                              s2_ctl,
  output logic                                  s2_ready,
  input  logic [2*(COORD_BITS+FRAC_BITS+2)-1:0] sq_x,
  input  logic [2*(COORD_BITS+FRAC_BITS+2)-1:0] sq_y,
  input  logic                                  off_screen,
  input  logic signed [COORD_BITS+1:0]          pixel_x,
  input  logic signed [COORD_BITS+1:0]          pixel_y,
  input  logic [2*COORD_BITS-1:0]               obstacle_r2,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_pixel_valid,
  output logic signed [COORD_BITS+1:0]          out_pixel_x,
  output logic signed [COORD_BITS+1:0]          out_pixel_y,
  output logic                                  out_hit,
  output logic                                  out_off_screen,
  output logic                                  out_ray_done
);

  localparam int POS_BITS = COORD_BITS + FRAC_BITS + 2;
  localparam int PIX_BITS = COORD_BITS + 2;
  localparam int THR_PAD  = 2*POS_BITS + 1 - 2*COORD_BITS - 2*FRAC_BITS;

  logic [2*POS_BITS:0] dist_sq, thresh;
  logic                in_circle;
  logic                out_valid_r, finished_r, finished_nxt;
  logic                pixel_valid_r, pixel_valid_nxt;
  logic [PIX_BITS-1:0] pixel_x_r, pixel_x_nxt, pixel_y_r, pixel_y_nxt;
  logic                hit_r, hit_nxt, off_r, off_nxt, done_r, done_nxt;

  assign s2_ready  = !out_valid_r || out_ready;
  assign dist_sq   = {1'b0, sq_x} + {1'b0, sq_y};
  assign thresh    = {{THR_PAD{1'b0}}, obstacle_r2, {(2*FRAC_BITS){1'b0}}};
  assign in_circle = dist_sq <= thresh;

  always_comb begin
    pixel_valid_nxt = 1'b0;
    pixel_x_nxt     = '0;
    pixel_y_nxt     = '0;
    hit_nxt         = 1'b0;
    off_nxt         = 1'b0;
    done_nxt        = 1'b0;
    finished_nxt    = finished_r;
    if (!s2_ctl.is_step) begin
      finished_nxt = 1'b0;
    end else if (finished_r) begin
      done_nxt = 1'b1;
    end else begin
      pixel_valid_nxt = 1'b1;
      pixel_x_nxt     = pixel_x;
      pixel_y_nxt     = pixel_y;
      hit_nxt         = in_circle;
      off_nxt         = off_screen;
      finished_nxt    = in_circle || off_screen;
      done_nxt        = finished_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      finished_r  <= 1'b1;
    end else if (s2_ready) begin
      out_valid_r <= s2_ctl.valid;
      if (s2_ctl.valid) begin
        finished_r <= finished_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s2_ctl.valid) begin
      pixel_valid_r <= pixel_valid_nxt;
      pixel_x_r     <= pixel_x_nxt;
      pixel_y_r     <= pixel_y_nxt;
      hit_r         <= hit_nxt;
      off_r         <= off_nxt;
      done_r        <= done_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_valid = pixel_valid_r;
  assign out_pixel_x     = pixel_x_r;
  assign out_pixel_y     = pixel_y_r;
  assign out_hit         = hit_r;
  assign out_off_screen  = off_r;
  assign out_ray_done    = done_r;

`ifndef SYNTHESIS
  a_end_flags_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && pixel_valid_r && (hit_r || off_r) |-> done_r)
    else $error("Hit or off-screen pixel without ray_done.");

  a_done_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> finished_r)
    else $error("Result reports ray_done while a ray is still active.");

  a_load_opens_ray: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !pixel_valid_r && !done_r |-> !finished_r)
    else $error("Load result left the ray marked finished.");
`endif

endmodule

// File: hw/rtl/ray_march_circle_occluder.sv
// Top level of the fixed-step ray march with a circular occluder.
// Depends on rmc_pkg, the three channel interfaces and the rmc_* stages.
`timescale 1ns / 1ps

// Usage:
// The input channel takes one item per transfer. A load item (mode 0) sets the
// ray origin in whole pixels and its direction in signed fixed point; a step item
// (mode 1) advances the ray by one direction vector. Every item yields exactly one
// result on the output channel, in order: a load gives an all-zero result, a step
// gives the truncated pixel with its hit, off_screen and ray_done flags, and a step
// after the ray has ended gives pixel_valid low with ray_done high.
// The configuration channel is always ready and writes one register per transfer;
// it is meant to be used while no item is in flight.
// An item passes the advance, geometry and resolve registers on its way to the
// output, and one item per cycle is sustained while the receiver is ready. The rate
// is set by the position adder, which closes its loop through the position
// register; the squares and the circle compare are in the two stages behind it.
// Reset loads the default obstacle and screen settings and leaves no active ray.
// When the receiver stalls, each stage holds its item, and the block keeps taking
// input until all three stages are full.

module ray_march_circle_occluder
  import rmc_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  rmc_in_if.sink   in_chan,
  rmc_out_if.source out_chan,
  rmc_cfg_if.sink  cfg_chan
);

  localparam int POS_BITS = COORD_BITS + FRAC_BITS + 2;

  logic [COORD_BITS-1:0]      obstacle_x, obstacle_y;
  logic [COORD_BITS:0]        screen_width, screen_height;
  logic [2*COORD_BITS-1:0]    obstacle_r2;
  rmc_ctl_t                   s1_ctl, s2_ctl;
  logic                       s1_ready, s2_ready;
  logic signed [POS_BITS-1:0] pos_x, pos_y;
  logic [2*POS_BITS-1:0]      sq_x, sq_y;
  logic                       off_screen;
  logic signed [COORD_BITS+1:0] pixel_x, pixel_y;

  rmc_cfg_regs #(.COORD_BITS(COORD_BITS)) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_chan.valid),
    .cfg_ready    (cfg_chan.ready),
    .cfg_index    (cfg_chan.index),
    .cfg_data     (cfg_chan.data),
    .obstacle_x   (obstacle_x),
    .obstacle_y   (obstacle_y),
    .screen_width (screen_width),
    .screen_height(screen_height),
    .obstacle_r2  (obstacle_r2)
  );

  rmc_advance #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_advance (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_mode   (in_chan.mode),
    .in_start_x(in_chan.start_x),
    .in_start_y(in_chan.start_y),
    .in_dir_x  (in_chan.dir_x),
    .in_dir_y  (in_chan.dir_y),
    .s1_ready  (s1_ready),
    .s1_ctl    (s1_ctl),
    .pos_x     (pos_x),
    .pos_y     (pos_y)
  );

  rmc_geom #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_geom (
    .clk          (clk),
    .rst_n        (rst_n),
    .s1_ctl       (s1_ctl),
    .s1_ready     (s1_ready),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .obstacle_x   (obstacle_x),
    .obstacle_y   (obstacle_y),
    .screen_width (screen_width),
    .screen_height(screen_height),
    .s2_ready     (s2_ready),
    .s2_ctl       (s2_ctl),
    .sq_x         (sq_x),
    .sq_y         (sq_y),
    .off_screen   (off_screen),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y)
  );

  rmc_resolve #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_resolve (
    .clk            (clk),
    .rst_n          (rst_n),
    .s2_ctl         (s2_ctl),
    .s2_ready       (s2_ready),
    .sq_x           (sq_x),
    .sq_y           (sq_y),
    .off_screen     (off_screen),
    .pixel_x        (pixel_x),
    .pixel_y        (pixel_y),
    .obstacle_r2    (obstacle_r2),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_pixel_valid(out_chan.pixel_valid),
    .out_pixel_x    (out_chan.pixel_x),
    .out_pixel_y    (out_chan.pixel_y),
    .out_hit        (out_chan.hit),
    .out_off_screen (out_chan.off_screen),
    .out_ray_done   (out_chan.ray_done)
  );

endmodule
